// ===== hdl/ssmcd_pkg.sv =====
// shared types, codes and constants of the serial servo and motor command decoder
package ssmcd_pkg;

    localparam logic [7:0] CHAR_LF    = 8'd10;
    localparam logic [7:0] CHAR_TAB   = 8'd9;
    localparam logic [7:0] CHAR_CR    = 8'd13;
    localparam logic [7:0] CHAR_SPACE = 8'd32;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_S     = 8'h53;
    localparam logic [7:0] CHAR_M     = 8'h4D;

    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_SERVO = 2'd1;
    localparam logic [1:0] KIND_MOTOR = 2'd2;

    localparam logic [1:0] STATUS_SERVO   = 2'd0;
    localparam logic [1:0] STATUS_MOTOR   = 2'd1;
    localparam logic [1:0] STATUS_IGNORED = 2'd2;

    localparam logic [1:0] CFG_SERVO_BASE = 2'd0;
    localparam logic [1:0] CFG_SERVO_SPAN = 2'd1;
    localparam logic [1:0] CFG_MOTOR_GAIN = 2'd2;

    localparam logic [15:0] SERVO_BASE_RESET = 16'd1000;
    localparam logic [15:0] SERVO_SPAN_RESET = 16'd1000;
    localparam logic [7:0]  MOTOR_GAIN_RESET = 8'd78;

    localparam logic [9:0]  MAG_MAX   = 10'd1023;
    localparam logic [9:0]  ANGLE_MAX = 10'd180;
    localparam logic [9:0]  SPEED_MAX = 10'd255;

    // floor(x / 45) = (x * DIV45_RECIP) >> DIV45_SHIFT for x below 2^22
    localparam logic [22:0] DIV45_RECIP = 23'd5965233;
    localparam int          DIV45_SHIFT = 28;

    typedef struct packed {
        logic [1:0] kind;
        logic [9:0] mag;
        logic       neg;
    } req_t;

    typedef struct packed {
        logic [15:0] servo_base;
        logic [15:0] servo_span;
        logic [7:0]  motor_gain;
    } cfg_t;

endpackage

// ===== hdl/serial_servo_motor_command_decoder_top.sv =====
// top level of the serial servo and motor command decoder
// Feed received ASCII bytes on s_; each newline item gives one result item on m_ with
// the status in m_tuser and the new PWM compare value in m_tdata, all other bytes give
// none. A byte is taken every cycle unless all four pipeline registers hold results while
// m_tready is low; after the newline is accepted, its result passes through the
// four-register result pipeline (request register, range check and multiply,
// reciprocal multiply for the divide by 180, offset add with saturation into the output
// register) and is then valid on m_.
// Registers on the cfg_ port: 0 servo_base, 1 servo_span, 2 motor_gain; write them only
// while no result is pending.
module serial_servo_motor_command_decoder_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [15:0] compare_value
    output logic [1:0]  m_tuser,    // [1:0] status
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import ssmcd_pkg::*;

    cfg_t cfg_reg;
    logic in_accept;
    logic req_valid;
    logic req_ready;
    req_t req;

    assign cfg_ready = 1'b1;
    assign s_tready  = req_ready;
    assign in_accept = s_tvalid && req_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.servo_base <= SERVO_BASE_RESET;
            cfg_reg.servo_span <= SERVO_SPAN_RESET;
            cfg_reg.motor_gain <= MOTOR_GAIN_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_SERVO_BASE: cfg_reg.servo_base <= cfg_data;
                CFG_SERVO_SPAN: cfg_reg.servo_span <= cfg_data;
                CFG_MOTOR_GAIN: cfg_reg.motor_gain <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    ssmcd_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .rx_byte   (s_tdata),
        .req_valid (req_valid),
        .req       (req)
    );

    ssmcd_compute u_compute (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .req_valid   (req_valid),
        .req         (req),
        .cfg         (cfg_reg),
        .req_ready   (req_ready),
        .out_ready   (m_tready),
        .out_valid   (m_tvalid),
        .out_status  (m_tuser),
        .out_compare (m_tdata)
    );

endmodule

// ===== hdl/ssmcd_parser.sv =====
// line parser: command byte, leading blanks, sign and decimal digits
module ssmcd_parser (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_accept,
    input  logic [7:0]    rx_byte,
    output logic          req_valid,
    output ssmcd_pkg::req_t req
);
    import ssmcd_pkg::*;

    localparam logic [1:0] PH_START  = 2'd0;
    localparam logic [1:0] PH_LEAD   = 2'd1;
    localparam logic [1:0] PH_DIGITS = 2'd2;
    localparam logic [1:0] PH_DONE   = 2'd3;

    logic [1:0] phase_reg, phase_next;
    logic [1:0] kind_reg, kind_next;
    logic [9:0] acc_reg, acc_next;
    logic       neg_reg, neg_next;

    logic        is_digit;
    logic        is_blank;
    logic [3:0]  digit;
    logic [13:0] acc_mul;

    assign is_digit = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
    assign is_blank = (rx_byte == CHAR_SPACE) || ((rx_byte >= CHAR_TAB) && (rx_byte <= CHAR_CR));
    assign digit    = 4'(rx_byte - CHAR_ZERO);
    assign acc_mul  = 14'({4'd0, acc_reg} * 14'd10) + {10'd0, digit};

    assign req.kind = kind_reg;
    assign req.mag  = acc_reg;
    assign req.neg  = neg_reg;

    always_comb begin
        phase_next = phase_reg;
        kind_next  = kind_reg;
        acc_next   = acc_reg;
        neg_next   = neg_reg;
        req_valid  = 1'b0;
        if (in_accept) begin
            if (rx_byte == CHAR_LF) begin
                req_valid  = 1'b1;
                phase_next = PH_START;
                kind_next  = KIND_NONE;
                acc_next   = '0;
                neg_next   = 1'b0;
            end else begin
                unique case (phase_reg)
                    PH_START: begin
                        priority if (rx_byte == CHAR_S) kind_next = KIND_SERVO;
                        else if (rx_byte == CHAR_M) kind_next = KIND_MOTOR;
                        else kind_next = KIND_NONE;
                        phase_next = PH_LEAD;
                    end
                    PH_LEAD: begin
                        priority if (is_blank) begin
                            phase_next = PH_LEAD;
                        end else if (rx_byte == CHAR_MINUS) begin
                            neg_next   = 1'b1;
                            phase_next = PH_DIGITS;
                        end else if (rx_byte == CHAR_PLUS) begin
                            phase_next = PH_DIGITS;
                        end else if (is_digit) begin
                            acc_next   = {6'd0, digit};
                            phase_next = PH_DIGITS;
                        end else begin
                            phase_next = PH_DONE;
                        end
                    end
                    PH_DIGITS: begin
                        if (is_digit) begin
                            acc_next = (acc_mul > {4'd0, MAG_MAX}) ? MAG_MAX : acc_mul[9:0];
                        end else begin
                            phase_next = PH_DONE;
                        end
                    end
                    default: phase_next = PH_DONE;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_START;
            kind_reg  <= KIND_NONE;
            acc_reg   <= '0;
            neg_reg   <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            kind_reg  <= kind_next;
            acc_reg   <= acc_next;
            neg_reg   <= neg_next;
        end
    end

endmodule

// ===== hdl/ssmcd_compute.sv =====
// result pipeline: range check, multiply, then for servo results divide by 180, offset and saturate
module ssmcd_compute (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            req_valid,
    input  ssmcd_pkg::req_t req,
    input  ssmcd_pkg::cfg_t cfg,
    output logic            req_ready,
    input  logic            out_ready,
    output logic            out_valid,
    output logic [1:0]      out_status,
    output logic [15:0]     out_compare
);
    import ssmcd_pkg::*;

    logic        v1_reg, v2_reg, v3_reg, v4_reg;
    req_t        req1_reg;
    logic [1:0]  st2_reg, st3_reg, st4_reg;
    logic [23:0] prod2_reg;
    logic [15:0] val3_reg, val4_reg;

    logic        rdy1, rdy2, rdy3, rdy4;
    logic        nonneg;
    logic [1:0]  st2_next;
    logic [15:0] mul_b;
    logic [44:0] recip_prod;
    logic [15:0] quot;
    logic [16:0] sum;

    assign rdy4      = !v4_reg || out_ready;
    assign rdy3      = !v3_reg || rdy4;
    assign rdy2      = !v2_reg || rdy3;
    assign rdy1      = !v1_reg || rdy2;
    assign req_ready = rdy1;

    assign nonneg = !req1_reg.neg || (req1_reg.mag == '0);

    always_comb begin
        priority if (req1_reg.kind == KIND_SERVO && nonneg && req1_reg.mag <= ANGLE_MAX)
            st2_next = STATUS_SERVO;
        else if (req1_reg.kind == KIND_MOTOR && nonneg && req1_reg.mag <= SPEED_MAX)
            st2_next = STATUS_MOTOR;
        else
            st2_next = STATUS_IGNORED;
    end

    assign mul_b      = (req1_reg.kind == KIND_SERVO) ? cfg.servo_span : {8'd0, cfg.motor_gain};
    assign recip_prod = {23'd0, prod2_reg[23:2]} * {22'd0, DIV45_RECIP};
    assign quot       = recip_prod[DIV45_SHIFT +: 16];
    assign sum        = {1'b0, cfg.servo_base} + {1'b0, val3_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= req_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && req_valid) req1_reg <= req;
        if (rdy2 && v1_reg) begin
            st2_reg   <= st2_next;
            prod2_reg <= {16'd0, req1_reg.mag[7:0]} * {8'd0, mul_b};
        end
        if (rdy3 && v2_reg) begin
            st3_reg  <= st2_reg;
            val3_reg <= (st2_reg == STATUS_SERVO) ? quot : prod2_reg[15:0];
        end
        if (rdy4 && v3_reg) begin
            st4_reg <= st3_reg;
            unique case (st3_reg)
                STATUS_SERVO: val4_reg <= sum[16] ? 16'hFFFF : sum[15:0];
                STATUS_MOTOR: val4_reg <= val3_reg;
                default:      val4_reg <= '0;
            endcase
        end
    end

    assign out_valid   = v4_reg;
    assign out_status  = st4_reg;
    assign out_compare = val4_reg;

endmodule
